@@ rtl/rgbi_pkg.sv @@
// Shared types and constants for the RGBI sync capture packer.
package rgbi_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned SYNC_W   = 12;
    localparam int unsigned SHIFT_W  = 10;
    localparam int unsigned FRAMES_W = 4;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;

    localparam logic signed [POS_W-1:0] POS_TOP    = 16'sh7FFF;
    localparam logic [SYNC_W-1:0]       SYNC_TOP   = 12'hFFF;
    localparam logic [FRAMES_W-1:0]     FRAMES_TOP = 4'd11;
    localparam logic [FRAMES_W-1:0]     SETTLE_FRAMES = 4'd10;

    localparam logic [SYNC_W-1:0] HALF_HSYNC_RESET = 12'd24;
    localparam logic [SYNC_W-1:0] VSYNC_RESET      = 12'd240;

    typedef enum logic [2:0] {
        REG_SEPARATE_SYNC = 3'd0,
        REG_SHIFT_X       = 3'd1,
        REG_SHIFT_Y       = 3'd2,
        REG_HALF_HSYNC    = 3'd3,
        REG_VSYNC_LEN     = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic                      separate_sync;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic [SYNC_W-1:0]         half_hsync_len;
        logic [SYNC_W-1:0]         vsync_len;
    } cfg_t;

    typedef struct packed {
        logic                write_enable;
        logic [ADDR_W-1:0]   write_address;
        logic [SAMPLE_W-1:0] write_data;
        logic                new_buffer;
    } result_t;

endpackage

@@ rtl/rgbi_apb_regs.sv @@
// APB configuration register bank for the RGBI capture packer.
module rgbi_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbi_pkg::PADDR_W-1:0]  paddr,
    input  logic [rgbi_pkg::PDATA_W-1:0]  pwdata,
    output logic [rgbi_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output rgbi_pkg::cfg_t                cfg
);

    rgbi_pkg::cfg_t cfg_reg;
    rgbi_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[rgbi_pkg::PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                rgbi_pkg::REG_SEPARATE_SYNC: cfg_next.separate_sync = pwdata[0];
                rgbi_pkg::REG_SHIFT_X: cfg_next.shift_x = pwdata[rgbi_pkg::SHIFT_W-1:0];
                rgbi_pkg::REG_SHIFT_Y: cfg_next.shift_y = pwdata[rgbi_pkg::SHIFT_W-1:0];
                rgbi_pkg::REG_HALF_HSYNC: begin
                    cfg_next.half_hsync_len = pwdata[rgbi_pkg::SYNC_W-1:0];
                end
                rgbi_pkg::REG_VSYNC_LEN: cfg_next.vsync_len = pwdata[rgbi_pkg::SYNC_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rgbi_pkg::REG_SEPARATE_SYNC: prdata = {31'b0, cfg_reg.separate_sync};
            rgbi_pkg::REG_SHIFT_X: prdata = {{22{cfg_reg.shift_x[9]}}, cfg_reg.shift_x};
            rgbi_pkg::REG_SHIFT_Y: prdata = {{22{cfg_reg.shift_y[9]}}, cfg_reg.shift_y};
            rgbi_pkg::REG_HALF_HSYNC: prdata = {20'b0, cfg_reg.half_hsync_len};
            rgbi_pkg::REG_VSYNC_LEN:  prdata = {20'b0, cfg_reg.vsync_len};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.separate_sync  <= 1'b0;
            cfg_reg.shift_x        <= '0;
            cfg_reg.shift_y        <= '0;
            cfg_reg.half_hsync_len <= rgbi_pkg::HALF_HSYNC_RESET;
            cfg_reg.vsync_len      <= rgbi_pkg::VSYNC_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/rgbi_capture_core.sv @@
// Sync detection, position tracking and pixel packing state for one sample per cycle while advance is high.
module rgbi_capture_core #(
    parameter int BUF_WIDTH  = 320,
    parameter int BUF_HEIGHT = 256,
    parameter int HSYNC_BIT  = 6,
    parameter int VSYNC_BIT  = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rgbi_pkg::cfg_t                  cfg,
    input  logic                            advance,
    input  logic [rgbi_pkg::SAMPLE_W-1:0]   sample,
    output rgbi_pkg::result_t               result
);

    localparam logic [7:0] HsMask = 8'b1 << HSYNC_BIT;
    localparam logic [7:0] VsMask = 8'b1 << VSYNC_BIT;
    localparam logic signed [15:0] BufWidthS  = 16'(BUF_WIDTH);
    localparam logic signed [15:0] BufHeightS = 16'(BUF_HEIGHT);
    localparam logic [26:0] BufWidthU = 27'(BUF_WIDTH);

    logic signed [15:0] column_pos_reg, column_pos_next;
    logic signed [15:0] line_pos_reg, line_pos_next;
    logic [3:0]         held_pixel_reg, held_pixel_next;
    logic [11:0]        sync_count_reg, sync_count_next;
    logic [3:0]         frames_seen_reg, frames_seen_next;
    logic               buffer_ready_reg, buffer_ready_next;
    logic [15:0]        write_pointer_reg, write_pointer_next;

    logic [7:0]         mask;
    logic               is_sync;
    logic signed [15:0] col_inc;
    logic               line_start;
    logic signed [15:0] line_inc;
    logic [26:0]        line_prod;
    logic [11:0]        sync_inc;
    logic               frame_start;
    logic               pix_write;

    always_comb begin
        mask       = cfg.separate_sync ? (HsMask | VsMask) : HsMask;
        is_sync    = (sample & mask) != mask;
        col_inc    = (column_pos_reg == rgbi_pkg::POS_TOP) ? rgbi_pkg::POS_TOP - 16'sd1
                                                           : column_pos_reg + 16'sd1;
        line_start = (sync_count_reg == cfg.half_hsync_len)
                     && (sync_count_reg != rgbi_pkg::SYNC_TOP);
        line_inc   = (line_start && line_pos_reg != rgbi_pkg::POS_TOP)
                     ? line_pos_reg + 16'sd1 : line_pos_reg;
        line_prod  = {12'b0, line_inc[14:0]} * BufWidthU;
        sync_inc   = (sync_count_reg != rgbi_pkg::SYNC_TOP) ? sync_count_reg + 12'd1
                                                            : sync_count_reg;
        frame_start = cfg.separate_sync ? ~sample[VSYNC_BIT] : (sync_inc >= cfg.vsync_len);
        pix_write  = col_inc[0] && buffer_ready_reg && !col_inc[15] && !line_pos_reg[15]
                     && (col_inc < BufWidthS) && (line_pos_reg < BufHeightS);

        column_pos_next    = col_inc;
        line_pos_next      = line_pos_reg;
        held_pixel_next    = held_pixel_reg;
        sync_count_next    = sync_count_reg;
        frames_seen_next   = frames_seen_reg;
        buffer_ready_next  = buffer_ready_reg;
        write_pointer_next = write_pointer_reg;
        result             = '0;

        if (is_sync) begin
            line_pos_next   = line_inc;
            sync_count_next = sync_inc;
            column_pos_next = {{6{~cfg.shift_x[9]}}, ~cfg.shift_x};
            if (line_start && !line_inc[15] && buffer_ready_reg) begin
                write_pointer_next = line_prod[16:1];
            end
            if (frame_start) begin
                if (!line_inc[15]) begin
                    if (frames_seen_reg > rgbi_pkg::SETTLE_FRAMES) begin
                        buffer_ready_next = 1'b1;
                        result.new_buffer = 1'b1;
                    end
                    if (frames_seen_reg < rgbi_pkg::FRAMES_TOP) begin
                        frames_seen_next = frames_seen_reg + 4'd1;
                    end
                end
                line_pos_next = {{6{~cfg.shift_y[9]}}, ~cfg.shift_y};
            end
        end else if (col_inc[0]) begin
            if (pix_write) begin
                result.write_enable  = 1'b1;
                result.write_address = write_pointer_reg;
                result.write_data    = {sample[3:0], held_pixel_reg};
                write_pointer_next   = write_pointer_reg + 16'd1;
            end
        end else begin
            sync_count_next = '0;
            held_pixel_next = sample[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_pos_reg    <= '0;
            line_pos_reg      <= '0;
            held_pixel_reg    <= '0;
            sync_count_reg    <= '0;
            frames_seen_reg   <= '0;
            buffer_ready_reg  <= 1'b0;
            write_pointer_reg <= '0;
        end else if (advance) begin
            column_pos_reg    <= column_pos_next;
            line_pos_reg      <= line_pos_next;
            held_pixel_reg    <= held_pixel_next;
            sync_count_reg    <= sync_count_next;
            frames_seen_reg   <= frames_seen_next;
            buffer_ready_reg  <= buffer_ready_next;
            write_pointer_reg <= write_pointer_next;
        end
    end

endmodule

@@ rtl/rgbi_sync_capture_packer_unit.sv @@
// Top level of the RGBI sync capture packer: input register, capture core, result register.
// Each sample transfer yields exactly one result transfer. A sample is taken into an
// input register, processed combinationally by the capture core and stored in a result
// register. A new sample is accepted every cycle while the result side keeps up; the
// result register holding an untaken result is what stalls the input side. The user must
// write configuration through the APB port only while idle; the block does not enforce it.
module rgbi_sync_capture_packer_unit #(
    parameter int BUF_WIDTH  = 320,
    parameter int BUF_HEIGHT = 256,
    parameter int HSYNC_BIT  = 6,
    parameter int VSYNC_BIT  = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rgbi_pkg::PADDR_W-1:0]   paddr,
    input  logic [rgbi_pkg::PDATA_W-1:0]   pwdata,
    output logic [rgbi_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rgbi_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_write_enable,
    output logic [rgbi_pkg::ADDR_W-1:0]    m_write_address,
    output logic [rgbi_pkg::SAMPLE_W-1:0]  m_write_data,
    output logic                           m_new_buffer
);

    rgbi_pkg::cfg_t    cfg;
    rgbi_pkg::result_t core_result;
    rgbi_pkg::result_t out_reg;
    logic [rgbi_pkg::SAMPLE_W-1:0] sample_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    rgbi_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbi_capture_core #(
        .BUF_WIDTH  (BUF_WIDTH),
        .BUF_HEIGHT (BUF_HEIGHT),
        .HSYNC_BIT  (HSYNC_BIT),
        .VSYNC_BIT  (VSYNC_BIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .sample  (sample_reg),
        .result  (core_result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_enable  = out_reg.write_enable;
    assign m_write_address = out_reg.write_address;
    assign m_write_data    = out_reg.write_data;
    assign m_new_buffer    = out_reg.new_buffer;

    a_nb_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_buffer |-> !m_write_enable)
        else $error("new buffer request coincides with a pixel write");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_write_address == '0 && m_write_data == '0)
        else $error("result payload not cleared without a write");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && $stable(sample_reg))
        else $error("pending sample lost during result stall");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed sample produced no result");

endmodule

@@ test/tb.sv @@
// Testbench for the RGBI sync capture packer: predicts every pixel-byte write and checks it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_WIDTH  = 320;
    localparam int BUF_HEIGHT = 256;
    localparam int HSYNC_BIT  = 6;
    localparam int VSYNC_BIT  = 5;

    typedef enum logic [1:0] {
        RUN_PIXEL,
        RUN_HSYNC,
        RUN_VSYNC,
        RUN_NOISE
    } run_kind_t;

    class write_scoreboard;
        rgbi_pkg::cfg_t     cfg;
        logic signed [15:0] column_pos;
        logic signed [15:0] line_pos;
        logic [3:0]         held_pixel;
        logic [11:0]        sync_count;
        logic [3:0]         frames_seen;
        logic               buffer_ready;
        logic [15:0]        write_pointer;
        rgbi_pkg::result_t  expected_writes[$];
        int                 mismatches;

        function new();
            cfg.separate_sync  = 1'b0;
            cfg.shift_x        = '0;
            cfg.shift_y        = '0;
            cfg.half_hsync_len = rgbi_pkg::HALF_HSYNC_RESET;
            cfg.vsync_len      = rgbi_pkg::VSYNC_RESET;
            column_pos    = '0;
            line_pos      = '0;
            held_pixel    = '0;
            sync_count    = '0;
            frames_seen   = '0;
            buffer_ready  = 1'b0;
            write_pointer = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(rgbi_pkg::reg_index_t idx, logic [31:0] v);
            case (idx)
                rgbi_pkg::REG_SEPARATE_SYNC: cfg.separate_sync  = v[0];
                rgbi_pkg::REG_SHIFT_X:       cfg.shift_x        = v[9:0];
                rgbi_pkg::REG_SHIFT_Y:       cfg.shift_y        = v[9:0];
                rgbi_pkg::REG_HALF_HSYNC:    cfg.half_hsync_len = v[11:0];
                rgbi_pkg::REG_VSYNC_LEN:     cfg.vsync_len      = v[11:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [7:0] s);
            logic [7:0]        mask;
            logic              frame_start;
            rgbi_pkg::result_t r;
            r = '0;
            mask = 8'(1) << HSYNC_BIT;
            if (cfg.separate_sync)
                mask = mask | (8'(1) << VSYNC_BIT);

            if (column_pos >= rgbi_pkg::POS_TOP)
                column_pos = rgbi_pkg::POS_TOP - 16'sd1;
            else
                column_pos = column_pos + 16'sd1;

            if ((s & mask) != mask) begin
                if (sync_count == cfg.half_hsync_len && sync_count < rgbi_pkg::SYNC_TOP) begin
                    if (line_pos < rgbi_pkg::POS_TOP)
                        line_pos = line_pos + 16'sd1;
                    if (line_pos >= 0 && buffer_ready)
                        write_pointer = 16'((int'(line_pos) * BUF_WIDTH) / 2);
                end
                if (sync_count < rgbi_pkg::SYNC_TOP)
                    sync_count = sync_count + 12'd1;
                column_pos = 16'(-int'(cfg.shift_x) - 1);

                if (!cfg.separate_sync)
                    frame_start = (sync_count >= cfg.vsync_len);
                else
                    frame_start = !s[VSYNC_BIT];

                if (frame_start) begin
                    if (line_pos >= 0) begin
                        if (frames_seen > rgbi_pkg::SETTLE_FRAMES) begin
                            buffer_ready = 1'b1;
                            r.new_buffer = 1'b1;
                        end
                        if (frames_seen < rgbi_pkg::FRAMES_TOP)
                            frames_seen = frames_seen + 4'd1;
                    end
                    line_pos = 16'(-int'(cfg.shift_y) - 1);
                end
            end else if (column_pos[0]) begin
                if (buffer_ready && column_pos >= 0 && line_pos >= 0 &&
                    int'(column_pos) < BUF_WIDTH && int'(line_pos) < BUF_HEIGHT) begin
                    r.write_enable  = 1'b1;
                    r.write_address = write_pointer;
                    r.write_data    = {s[3:0], held_pixel};
                    write_pointer   = write_pointer + 16'd1;
                end
            end else begin
                sync_count = '0;
                held_pixel = s[3:0];
            end
            expected_writes.push_back(r);
        endfunction

        function void check_write(rgbi_pkg::result_t got);
            rgbi_pkg::result_t want;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: we=%0d addr=%0d data=%02h nb=%0d",
                             got.write_enable, got.write_address, got.write_data,
                             got.new_buffer);
                return;
            end
            want = expected_writes.pop_front();
            if (got.write_enable !== want.write_enable ||
                got.write_address !== want.write_address ||
                got.write_data !== want.write_data ||
                got.new_buffer !== want.new_buffer) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: exp we=%0d addr=%0d data=%02h nb=%0d,",
                           want.write_enable, want.write_address, want.write_data,
                           want.new_buffer);
                    $display(" got we=%0d addr=%0d data=%02h nb=%0d",
                             got.write_enable, got.write_address,
                             got.write_data, got.new_buffer);
                end
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [rgbi_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [rgbi_pkg::PDATA_W-1:0]  pwdata  = '0;
    logic [rgbi_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          s_valid  = 1'b0;
    logic                          s_ready;
    logic [rgbi_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                          m_valid;
    logic                          m_ready  = 1'b0;
    logic                          m_write_enable;
    logic [rgbi_pkg::ADDR_W-1:0]   m_write_address;
    logic [rgbi_pkg::SAMPLE_W-1:0] m_write_data;
    logic                          m_new_buffer;

    write_scoreboard sb;
    bit              no_gaps = 1'b0;
    int              items_sent = 0;

    rgbi_sync_capture_packer_unit #(
        .BUF_WIDTH (BUF_WIDTH),
        .BUF_HEIGHT(BUF_HEIGHT),
        .HSYNC_BIT (HSYNC_BIT),
        .VSYNC_BIT (VSYNC_BIT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_write_address(m_write_address),
        .m_write_data   (m_write_data),
        .m_new_buffer   (m_new_buffer)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_sample(s_sample);
            if (m_valid && m_ready)
                sb.check_write(rgbi_pkg::result_t'({m_write_enable, m_write_address,
                                                    m_write_data, m_new_buffer}));
        end
    end

    task automatic send_sample(input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_run(input int n, input run_kind_t kind);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            case (kind)
                RUN_PIXEL: begin
                    b[HSYNC_BIT] = 1'b1;
                    if (sb.cfg.separate_sync)
                        b[VSYNC_BIT] = 1'b1;
                end
                RUN_HSYNC: begin
                    b[HSYNC_BIT] = 1'b0;
                    if (sb.cfg.separate_sync)
                        b[VSYNC_BIT] = 1'b1;
                end
                RUN_VSYNC: begin
                    b[VSYNC_BIT] = 1'b0;
                    if (!sb.cfg.separate_sync)
                        b[HSYNC_BIT] = 1'b0;
                end
                default: ;
            endcase
            send_sample(b);
        end
    endtask

    function automatic int sync_span();
        return (sb.cfg.half_hsync_len > 12) ? 12 : int'(sb.cfg.half_hsync_len);
    endfunction

    task automatic send_vsync();
        if (sb.cfg.separate_sync)
            send_run($urandom_range(1, 3), RUN_VSYNC);
        else
            send_run(((sb.cfg.vsync_len > 40) ? 40 : int'(sb.cfg.vsync_len)) +
                     $urandom_range(0, 2), RUN_HSYNC);
    endtask

    task automatic send_line();
        int pick;
        int len;
        send_run(sync_span() + 1 + $urandom_range(0, 1), RUN_HSYNC);
        pick = $urandom_range(0, 99);
        if (pick < 6)
            len = $urandom_range(300, 340);
        else if (pick < 30)
            len = $urandom_range(1, 8);
        else
            len = $urandom_range(2, 40);
        send_run(len, RUN_PIXEL);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_writes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input rgbi_pkg::reg_index_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic configure(input logic sep, input logic signed [9:0] sx,
                             input logic signed [9:0] sy, input logic [11:0] half,
                             input logic [11:0] vlen);
        wait_drained();
        reg_write(rgbi_pkg::REG_SEPARATE_SYNC, {31'b0, sep});
        reg_write(rgbi_pkg::REG_SHIFT_X, {22'b0, sx});
        reg_write(rgbi_pkg::REG_SHIFT_Y, {22'b0, sy});
        reg_write(rgbi_pkg::REG_HALF_HSYNC, {20'b0, half});
        reg_write(rgbi_pkg::REG_VSYNC_LEN, {20'b0, vlen});
    endtask

    task automatic random_phase(input int quota, input bit steady);
        int                 start;
        int                 pause_at;
        int                 pick;
        bit                 paused;
        logic               sep;
        logic signed [9:0]  sx;
        logic signed [9:0]  sy;
        logic [11:0]        half;
        logic [11:0]        vlen;
        sep  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        sx   = (pick < 15) ? -10'sd512 : (pick < 30) ? 10'sd511 :
               10'(int'($urandom_range(0, 8)) - 4);
        pick = $urandom_range(0, 99);
        sy   = (pick < 15) ? -10'sd512 : (pick < 30) ? 10'sd511 :
               10'(int'($urandom_range(0, 6)) - 3);
        half = ($urandom_range(0, 99) < 10) ? 12'd4095 : 12'($urandom_range(0, 5));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            vlen = 12'd0;
        else if (pick < 20)
            vlen = 12'd4095;
        else
            vlen = 12'(((half > 12) ? 12 : int'(half)) + $urandom_range(4, 10));
        configure(sep, sx, sy, half, vlen);
        no_gaps  = steady;
        start    = items_sent;
        pause_at = start + $urandom_range(20, quota - 20);
        paused   = 1'b0;
        while (items_sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_vsync();
            else if (pick < 80)
                send_line();
            else if (pick < 90)
                send_run($urandom_range(1, 8), RUN_NOISE);
            else
                send_run($urandom_range(1, sync_span() + 3), RUN_HSYNC);
            if (!paused && items_sent >= pause_at) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [7:0] opening [16];
        opening = '{8'h00, 8'hFF, 8'h40, 8'h20, 8'h60, 8'h0F, 8'hF0, 8'h55,
                    8'hAA, 8'h7F, 8'h80, 8'hBF, 8'hDF, 8'h9F, 8'h10, 8'hEF};
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no buffer yet: nothing may be written
        foreach (opening[i])
            send_sample(opening[i]);

        // settle frames until a buffer is requested
        configure(1'b0, 10'sd0, 10'sd0, 12'd2, 12'd8);
        repeat (14) begin
            send_vsync();
            send_run(4, RUN_PIXEL);
        end
        configure(1'b1, 10'sd0, 10'sd0, 12'd2, 12'd8);
        repeat (2) begin
            send_vsync();
            send_line();
        end

        for (int p = 0; p < 4; p++)
            random_phase(100, p == 2);

        // pointer wrap: park the pointer near the top, then write from a cropped frame start
        configure(1'b1, 10'sd0, -10'sd400, 12'd0, 12'd4095);
        send_run(1, RUN_VSYNC);
        repeat (11) begin
            send_run(1, RUN_HSYNC);
            send_run(1, RUN_PIXEL);
        end
        configure(1'b1, 10'sd0, -10'sd1, 12'd4095, 12'd4095);
        send_run(1, RUN_VSYNC);
        send_run(200, RUN_PIXEL);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_writes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
